// ===== rtl/hsa_pkg.sv =====
// Shared types for the ascending heap sort block.
// Holds the sequencer state enum and the command and status structs.
// No dependencies.
package hsa_pkg;

  localparam int MAX_ITEMS_DEF = 64;
  localparam int DATA_W        = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BINIT,
    ST_BNEXT,
    ST_XNEXT,
    ST_XRD0,
    ST_XRD1,
    ST_XWR0,
    ST_XWR1,
    ST_SRD,
    ST_SNODE,
    ST_SLEFT,
    ST_SRIGHT,
    ST_SCHK,
    ST_SSWAP,
    ST_ORD,
    ST_OLOAD
  } state_t;

  // read address select
  typedef enum logic [2:0] {
    RD_POS,
    RD_LEFT,
    RD_RIGHT,
    RD_ROOT,
    RD_PEND,
    RD_OUT
  } rd_sel_t;

  // write port select
  typedef enum logic [2:0] {
    WR_NONE,
    WR_IN,
    WR_ROOT_RDATA,
    WR_PEND_NV,
    WR_POS_BV,
    WR_BI_NV
  } wr_sel_t;

  typedef struct packed {
    logic    store;       // input transfer: count it or mark overflow
    logic    build_init;  // limit <= count, pass <= count/2, out index <= 0
    logic    build_step;  // pos <= pass-1, pass <= pass-1
    logic    ext_init;    // pass <= count
    logic    xchg_done;   // limit <= pass-1, pass <= pass-1, pos <= 0
    logic    ld_node;     // node and big value <= read data, big index <= pos
    logic    take_left;
    logic    take_right;
    logic    descend;     // pos <= big index
    logic    out_load;
    logic    run_clr;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
  } cmd_t;

  typedef struct packed {
    logic p_zero;
    logic left_ok;
    logic right_ok;
    logic gt;
    logic big_is_node;
    logic out_free;
    logic out_last;
  } stat_t;

endpackage

// ===== rtl/hsa_ctrl.sv =====
// Sequencer for the heap sort: load, heap build, extraction and read-out.
// Drives the datapath through cmd_t and reacts to stat_t; uses hsa_pkg.
module hsa_ctrl
  import hsa_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  input  logic  s_tlast,
  output logic  s_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;
  logic   build_phase, build_phase_next;
  state_t sift_ret;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      build_phase <= 1'b0;
    end else begin
      state       <= state_next;
      build_phase <= build_phase_next;
    end
  end

  // where a finished sift-down goes back to
  assign sift_ret = build_phase ? ST_BNEXT : ST_XNEXT;

  always_comb begin
    state_next       = state;
    build_phase_next = build_phase;
    unique case (state)
      ST_IDLE:   if (s_tvalid && s_tlast) state_next = ST_BINIT;
      ST_BINIT: begin
        state_next       = ST_BNEXT;
        build_phase_next = 1'b1;
      end
      ST_BNEXT: begin
        if (stat.p_zero) begin
          state_next       = ST_XNEXT;
          build_phase_next = 1'b0;
        end else begin
          state_next = ST_SRD;
        end
      end
      ST_XNEXT:  state_next = stat.p_zero ? ST_ORD : ST_XRD0;
      ST_XRD0:   state_next = ST_XRD1;
      ST_XRD1:   state_next = ST_XWR0;
      ST_XWR0:   state_next = ST_XWR1;
      ST_XWR1:   state_next = ST_SRD;
      ST_SRD:    state_next = ST_SNODE;
      ST_SNODE:  state_next = stat.left_ok ? ST_SLEFT : sift_ret;
      ST_SLEFT:  state_next = stat.right_ok ? ST_SRIGHT : ST_SCHK;
      ST_SRIGHT: state_next = ST_SCHK;
      ST_SCHK:   state_next = stat.big_is_node ? sift_ret : ST_SSWAP;
      ST_SSWAP:  state_next = ST_SRD;
      ST_ORD:    if (stat.out_free) state_next = ST_OLOAD;
      ST_OLOAD:  state_next = stat.out_last ? ST_IDLE : ST_ORD;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_POS;
    cmd.wr_sel = WR_NONE;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.store  = 1'b1;
          cmd.wr_sel = WR_IN;
        end
      end
      ST_BINIT:  cmd.build_init = 1'b1;
      ST_BNEXT: begin
        if (stat.p_zero) cmd.ext_init = 1'b1;
        else             cmd.build_step = 1'b1;
      end
      ST_XNEXT:  cmd.rd_sel = RD_ROOT;
      ST_XRD0:   cmd.rd_sel = RD_ROOT;
      ST_XRD1: begin
        cmd.rd_sel  = RD_PEND;
        cmd.ld_node = 1'b1;
      end
      ST_XWR0:   cmd.wr_sel = WR_ROOT_RDATA;
      ST_XWR1: begin
        cmd.wr_sel    = WR_PEND_NV;
        cmd.xchg_done = 1'b1;
      end
      ST_SRD:    cmd.rd_sel = RD_POS;
      ST_SNODE: begin
        cmd.ld_node = 1'b1;
        cmd.rd_sel  = RD_LEFT;
      end
      ST_SLEFT: begin
        cmd.take_left = stat.gt;
        cmd.rd_sel    = RD_RIGHT;
      end
      ST_SRIGHT: cmd.take_right = stat.gt;
      ST_SCHK:   if (!stat.big_is_node) cmd.wr_sel = WR_POS_BV;
      ST_SSWAP: begin
        cmd.wr_sel  = WR_BI_NV;
        cmd.descend = 1'b1;
      end
      ST_ORD:    cmd.rd_sel = RD_OUT;
      ST_OLOAD: begin
        cmd.out_load = 1'b1;
        cmd.run_clr  = stat.out_last;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/hsa_dp.sv =====
// Datapath of the heap sort: element memory, heap indexes, compare and output register.
// Controlled by hsa_ctrl through cmd_t and stat_t; uses hsa_pkg.
module hsa_dp
  import hsa_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
)
(
  input  logic              clk,
  input  logic              rst,
  input  logic [DATA_W-1:0] s_tdata,
  input  cmd_t              cmd,
  output stat_t             stat,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,
  output logic              m_tlast,
  output logic              m_tuser
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int IW = AW + 2;

  logic [DATA_W-1:0] mem [MAX_ITEMS];

  logic [CW-1:0]       cnt;
  logic                ovf;
  logic [CW-1:0]       lim;
  logic [CW-1:0]       pass;
  logic [CW-1:0]       k;
  logic [AW-1:0]       pos;
  logic [AW-1:0]       bi;
  logic signed [DATA_W-1:0] nv;
  logic signed [DATA_W-1:0] bv;
  logic signed [DATA_W-1:0] rdata;

  logic [CW-1:0] pass_m1;
  logic [IW-1:0] left_i, right_i, lim_i;
  logic          room;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [DATA_W-1:0] wdata;
  logic          wen;

  assign pass_m1 = pass - CW'(1);
  assign left_i  = {1'b0, pos, 1'b1};
  assign right_i = {1'b0, pos, 1'b0} + IW'(2);
  assign lim_i   = IW'(lim);
  assign room    = cnt < CW'(MAX_ITEMS);

  assign stat.p_zero      = pass == '0;
  assign stat.left_ok     = left_i < lim_i;
  assign stat.right_ok    = right_i < lim_i;
  assign stat.gt          = rdata > bv;
  assign stat.big_is_node = bi == pos;
  assign stat.out_free    = !m_tvalid || m_tready;
  assign stat.out_last    = (k + CW'(1)) == cnt;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_POS:   raddr = pos;
      RD_LEFT:  raddr = left_i[AW-1:0];
      RD_RIGHT: raddr = right_i[AW-1:0];
      RD_ROOT:  raddr = '0;
      RD_PEND:  raddr = pass_m1[AW-1:0];
      RD_OUT:   raddr = k[AW-1:0];
      default:  raddr = pos;
    endcase
  end

  always_comb begin
    wen   = 1'b1;
    waddr = pos;
    wdata = bv;
    unique case (cmd.wr_sel)
      WR_NONE:       wen = 1'b0;
      WR_IN: begin
        wen   = room;
        waddr = cnt[AW-1:0];
        wdata = s_tdata;
      end
      WR_ROOT_RDATA: begin
        waddr = '0;
        wdata = rdata;
      end
      WR_PEND_NV: begin
        waddr = pass_m1[AW-1:0];
        wdata = nv;
      end
      WR_POS_BV: begin
        waddr = pos;
        wdata = bv;
      end
      WR_BI_NV: begin
        waddr = bi;
        wdata = nv;
      end
      default:       wen = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // set bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      ovf <= 1'b0;
    end else if (cmd.run_clr) begin
      cnt <= '0;
      ovf <= 1'b0;
    end else if (cmd.store) begin
      if (room) cnt <= cnt + CW'(1);
      else      ovf <= 1'b1;
    end
  end

  // heap indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      lim  <= '0;
      pass <= '0;
      pos  <= '0;
      k    <= '0;
    end else begin
      if (cmd.build_init) begin
        lim  <= cnt;
        pass <= cnt >> 1;
        k    <= '0;
      end
      if (cmd.build_step) begin
        pos  <= pass_m1[AW-1:0];
        pass <= pass_m1;
      end
      if (cmd.ext_init) pass <= cnt;
      if (cmd.xchg_done) begin
        lim  <= pass_m1;
        pass <= pass_m1;
        pos  <= '0;
      end
      if (cmd.descend) pos <= bi;
      if (cmd.out_load) k <= k + CW'(1);
    end
  end

  // node value and current largest of node and children
  always_ff @(posedge clk) begin
    if (cmd.ld_node) begin
      nv <= rdata;
      bv <= rdata;
      bi <= pos;
    end else if (cmd.take_left) begin
      bv <= rdata;
      bi <= left_i[AW-1:0];
    end else if (cmd.take_right) begin
      bv <= rdata;
      bi <= right_i[AW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= rdata;
      m_tlast <= stat.out_last;
      m_tuser <= ovf;
    end
  end

endmodule

// ===== rtl/heap_sort_ascending.sv =====
// Top level of the ascending heap sort block.
// Instantiates hsa_ctrl (sequencer) and hsa_dp (memory and datapath); uses hsa_pkg.
//
// Input stream: one signed 32-bit element per transfer, tlast on the final
// element of a set. Up to MAX_ITEMS elements are kept; further ones are
// discarded and the set is flagged as having dropped items.
// The final transfer starts the sort: a max-heap is built in the element memory
// and then shrunk, root swapped to the end and sifted down each time.
// Output stream: every stored element in ascending order, tlast on the largest,
// tuser set on all results of a set that lost elements.
// Loading accepts one element per cycle. Each sift-down level reads the node and
// then the left and right children on the single memory read port and compares;
// a level that swaps then does so with two writes. A root exchange reads the
// root and the last heap element and writes them back swapped.
// Read-out fetches each result from memory and loads it into the output register.
// Only one set is in work at a time; input is refused from the final transfer
// until the last result has been loaded into the output register.
// A receiver stall holds the output register and pauses the read-out.
// Reset empties the set and the output register; memory contents are not cleared.
module heap_sort_ascending
  import hsa_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
)
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,   // [31:0] value
  input  logic              s_tlast,   // last_item
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // [31:0] sorted_value
  output logic              m_tlast,   // last_result
  output logic              m_tuser    // [0] dropped
);

  cmd_t  cmd;
  stat_t stat;

  hsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hsa_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
